### hw/rtl/atlc_pkg.sv
// Shared constants for the adaptive traffic light controller.
// Register index codes, reset values and stream field positions.
// No dependencies.
package atlc_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_GREEN_NORMAL  = 3'd0;
	localparam logic [2:0] CFG_GREEN_DELAYED = 3'd1;
	localparam logic [2:0] CFG_YELLOW        = 3'd2;
	localparam logic [2:0] CFG_CHASE_ROUNDS  = 3'd3;
	localparam logic [2:0] CFG_LOW_LIMIT     = 3'd4;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 6;

	// Register reset values
	localparam logic [3:0] RST_GREEN_NORMAL  = 4'd3;
	localparam logic [3:0] RST_GREEN_DELAYED = 4'd4;
	localparam logic [3:0] RST_YELLOW        = 4'd1;
	localparam logic [5:0] RST_CHASE_ROUNDS  = 6'd10;
	localparam logic [1:0] RST_LOW_LIMIT     = 2'd3;

	// Stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int WHITE_W     = 6;

	// Output tdata bit positions
	localparam int O_VERT_GREEN  = 0;
	localparam int O_VERT_YELLOW = 1;
	localparam int O_VERT_RED    = 2;
	localparam int O_HORZ_GREEN  = 3;
	localparam int O_HORZ_YELLOW = 4;
	localparam int O_HORZ_RED    = 5;
	localparam int O_VERT_WHITE  = 6;
	localparam int O_HORZ_WHITE  = 12;

	// Index of the last chase position in a round (positions 0 to CHASE_LAST)
	localparam logic [1:0] CHASE_LAST = 2'd2;

endpackage

### hw/rtl/adaptive_traffic_light_controller.sv
// Adaptive traffic light controller: one tick in, one lamp pattern out.
// An accepted tick passes through the input register and then the result register.
// Throughput: one tick per cycle while the output is not stalled.
// Reset (arst_n low, asynchronous): vertical green, normal mode, counters and peaks
// cleared, configuration registers at their defaults, both stages empty.
// Depends on atlc_pkg.
module adaptive_traffic_light_controller #(
	parameter int LEDS_PER_LANE = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_we,
	input  logic [atlc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [atlc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// tick stream in
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: [1:0] lane0_level, [3:2] lane1_level, [7:4] zero
	input  logic [atlc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// lamp stream out
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// tdata: [0] vert_green, [1] vert_yellow, [2] vert_red, [3] horz_green,
	// [4] horz_yellow, [5] horz_red, [11:6] vert_white, [17:12] horz_white, [23:18] zero
	output logic [atlc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	// configuration registers
	logic [3:0] green_normal_q, green_delayed_q, yellow_q;
	logic [5:0] chase_rounds_q;
	logic [1:0] low_limit_q;

	// sequencer state
	logic       dir_q, in_yellow_q, delayed_q;
	logic [3:0] interval_q;
	logic [5:0] round_q;
	logic [1:0] chase_q, peak0_q, peak1_q;

	// stage registers
	logic       in_valid_s1;
	logic [1:0] lane0_s1, lane1_s1;
	logic       out_valid_s2;
	logic [atlc_pkg::OUT_TDATA_W-1:0] out_data_s2;

	logic advance;

	// next-state and result signals
	logic       dir_n, in_yellow_n, delayed_n;
	logic [3:0] interval_n, interval_inc, limit;
	logic [5:0] round_n, round_inc;
	logic [1:0] chase_n, peak0_n, peak1_n, pk0, pk1;
	logic       sample;
	logic [atlc_pkg::WHITE_W-1:0] active_white, waiting_white, vert_white, horz_white;
	logic       lamp_g, lamp_y;
	logic [atlc_pkg::OUT_TDATA_W-1:0] result;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			green_normal_q  <= atlc_pkg::RST_GREEN_NORMAL;
			green_delayed_q <= atlc_pkg::RST_GREEN_DELAYED;
			yellow_q        <= atlc_pkg::RST_YELLOW;
			chase_rounds_q  <= atlc_pkg::RST_CHASE_ROUNDS;
			low_limit_q     <= atlc_pkg::RST_LOW_LIMIT;
		end else if (cfg_we) begin
			case (cfg_addr)
				atlc_pkg::CFG_GREEN_NORMAL:  green_normal_q  <= cfg_wdata[3:0];
				atlc_pkg::CFG_GREEN_DELAYED: green_delayed_q <= cfg_wdata[3:0];
				atlc_pkg::CFG_YELLOW:        yellow_q        <= cfg_wdata[3:0];
				atlc_pkg::CFG_CHASE_ROUNDS:  chase_rounds_q  <= cfg_wdata[5:0];
				atlc_pkg::CFG_LOW_LIMIT:     low_limit_q     <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves on when the result register is empty or being taken
	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = out_data_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			lane0_s1 <= s_axis_tdata[1:0];
			lane1_s1 <= s_axis_tdata[3:2];
		end
	end

	// peak tracking, sampled on the first tick of an interval
	always_comb begin
		sample = (round_q == 6'd0) && (chase_q == 2'd0);
		pk0    = (sample && lane0_s1 > peak0_q) ? lane0_s1 : peak0_q;
		pk1    = (sample && lane1_s1 > peak1_q) ? lane1_s1 : peak1_q;
	end

	// white LED patterns: queue on waiting side, chase on active side
	always_comb begin
		for (int b = 0; b < atlc_pkg::WHITE_W; b++) begin
			if (b < LEDS_PER_LANE) begin
				waiting_white[b] = b < int'(pk0);
				active_white[b]  = (b == int'(chase_q)) && (chase_q <= atlc_pkg::CHASE_LAST);
			end else if (b < 2 * LEDS_PER_LANE) begin
				waiting_white[b] = (b - LEDS_PER_LANE) < int'(pk1);
				active_white[b]  = ((b - LEDS_PER_LANE) == int'(chase_q)) &&
				                   (chase_q <= atlc_pkg::CHASE_LAST);
			end else begin
				waiting_white[b] = 1'b0;
				active_white[b]  = 1'b0;
			end
		end
	end

	// lamp assembly
	always_comb begin
		lamp_g     = !in_yellow_q;
		lamp_y     = in_yellow_q;
		vert_white = dir_q ? waiting_white : active_white;
		horz_white = dir_q ? active_white : waiting_white;
		result     = '0;
		result[atlc_pkg::O_VERT_GREEN]  = !dir_q && lamp_g;
		result[atlc_pkg::O_VERT_YELLOW] = !dir_q && lamp_y;
		result[atlc_pkg::O_VERT_RED]    = dir_q;
		result[atlc_pkg::O_HORZ_GREEN]  = dir_q && lamp_g;
		result[atlc_pkg::O_HORZ_YELLOW] = dir_q && lamp_y;
		result[atlc_pkg::O_HORZ_RED]    = !dir_q;
		result[atlc_pkg::O_VERT_WHITE +: atlc_pkg::WHITE_W] = vert_white;
		result[atlc_pkg::O_HORZ_WHITE +: atlc_pkg::WHITE_W] = horz_white;
	end

	// counter chain: chase -> round -> interval -> phase
	always_comb begin
		dir_n        = dir_q;
		in_yellow_n  = in_yellow_q;
		delayed_n    = delayed_q;
		interval_n   = interval_q;
		round_n      = round_q;
		chase_n      = chase_q + 2'd1;
		peak0_n      = pk0;
		peak1_n      = pk1;
		round_inc    = round_q + 6'd1;
		interval_inc = interval_q + 4'd1;
		limit        = in_yellow_q ? yellow_q : (delayed_q ? green_delayed_q : green_normal_q);
		if (chase_q >= atlc_pkg::CHASE_LAST) begin
			chase_n = 2'd0;
			round_n = round_inc;
			if (round_inc == 6'd0 || round_inc >= chase_rounds_q) begin
				round_n    = 6'd0;
				interval_n = interval_inc;
				if (interval_inc == 4'd0 || interval_inc >= limit) begin
					interval_n = 4'd0;
					if (!in_yellow_q) begin
						in_yellow_n = 1'b1;
					end else begin
						in_yellow_n = 1'b0;
						delayed_n   = (pk0 < low_limit_q) && (pk1 < low_limit_q);
						dir_n       = !dir_q;
						peak0_n     = 2'd0;
						peak1_n     = 2'd0;
					end
				end
			end
		end
	end

	// state update on each processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= 1'b0;
			in_yellow_q <= 1'b0;
			delayed_q   <= 1'b0;
			interval_q  <= 4'd0;
			round_q     <= 6'd0;
			chase_q     <= 2'd0;
			peak0_q     <= 2'd0;
			peak1_q     <= 2'd0;
		end else if (advance) begin
			dir_q       <= dir_n;
			in_yellow_q <= in_yellow_n;
			delayed_q   <= delayed_n;
			interval_q  <= interval_n;
			round_q     <= round_n;
			chase_q     <= chase_n;
			peak0_q     <= peak0_n;
			peak1_q     <= peak1_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2 <= result;
		end
	end

endmodule

### hw/rtl/atlc_checker.sv
// Port-level checker for the adaptive traffic light controller, with its bind.
// Depends on atlc_pkg and adaptive_traffic_light_controller.
module atlc_port_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [atlc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one lamp per direction, exactly one direction red
	a_lamps: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			$onehot(m_axis_tdata[atlc_pkg::O_VERT_RED:atlc_pkg::O_VERT_GREEN]) &&
			$onehot(m_axis_tdata[atlc_pkg::O_HORZ_RED:atlc_pkg::O_HORZ_GREEN]) &&
			(m_axis_tdata[atlc_pkg::O_VERT_RED] != m_axis_tdata[atlc_pkg::O_HORZ_RED]))
		else $error("inconsistent lamp pattern");

	// a newly valid result must trace back to an accepted tick transaction
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without tick");

	// with an empty output side the input never stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind adaptive_traffic_light_controller atlc_port_checker u_atlc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
